// ===== hw/rtl/fpa_pkg.sv =====
// Shared types, operation codes and widths for the fixed-point ALU.
package fpa_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 8;
    localparam int NUM_W        = DATA_W + FRAC_BITS;
    localparam int ACTION_W     = 4;
    localparam int DIV_STAGES   = DATA_W;
    localparam int DIV_LAT      = DIV_STAGES + 2;
    localparam int MUL_LAT      = 2;
    localparam int ALIGN_DEPTH  = DIV_LAT - MUL_LAT;

    localparam logic [ACTION_W-1:0] OP_ADD      = 4'd0;
    localparam logic [ACTION_W-1:0] OP_SUB      = 4'd1;
    localparam logic [ACTION_W-1:0] OP_MUL      = 4'd2;
    localparam logic [ACTION_W-1:0] OP_DIV      = 4'd3;
    localparam logic [ACTION_W-1:0] OP_GT       = 4'd4;
    localparam logic [ACTION_W-1:0] OP_LT       = 4'd5;
    localparam logic [ACTION_W-1:0] OP_GE       = 4'd6;
    localparam logic [ACTION_W-1:0] OP_LE       = 4'd7;
    localparam logic [ACTION_W-1:0] OP_EQ       = 4'd8;
    localparam logic [ACTION_W-1:0] OP_NE       = 4'd9;
    localparam logic [ACTION_W-1:0] OP_MIN      = 4'd10;
    localparam logic [ACTION_W-1:0] OP_MAX      = 4'd11;
    localparam logic [ACTION_W-1:0] OP_INC      = 4'd12;
    localparam logic [ACTION_W-1:0] OP_DEC      = 4'd13;
    localparam logic [ACTION_W-1:0] OP_FROM_INT = 4'd14;
    localparam logic [ACTION_W-1:0] OP_TO_INT   = 4'd15;

    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic                     overflowed;
        logic                     divided_by_zero;
    } rsp_item_t;

    // Magnitude of a signed word as unsigned (most negative value fits)
    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

// ===== hw/rtl/fpa_mul.sv =====
// Two-stage rounding fixed-point multiplier with saturation.
module fpa_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output fpa_pkg::rsp_item_t           result
);
    import fpa_pkg::*;

    logic [2*DATA_W-1:0] prod_reg;
    logic                neg_reg;
    rsp_item_t           result_reg;
    rsp_item_t           result_next;
    logic [2*DATA_W-1:0] rounded;
    logic [2*DATA_W-1:0] half;

    // Multiply magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mag(operand_a) * mag(operand_b);
            neg_reg  <= operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        end
    end

    // Round half away from zero, restore sign, saturate
    always_comb
    begin
        half        = {{(2*DATA_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
        rounded     = (prod_reg + half) >> FRAC_BITS;
        result_next = '0;
        if (neg_reg && rounded > {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}})
        begin
            result_next.result_value = MIN_VAL;
            result_next.overflowed   = 1'b1;
        end
        else if (!neg_reg && rounded > {{DATA_W{1'b0}}, 1'b0, {(DATA_W-1){1'b1}}})
        begin
            result_next.result_value = MAX_VAL;
            result_next.overflowed   = 1'b1;
        end
        else
        begin
            result_next.result_value = neg_reg ? -rounded[DATA_W-1:0] : rounded[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/fpa_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, rounded and saturated.
module fpa_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output fpa_pkg::rsp_item_t                result
);
    import fpa_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] dvsr;
        logic              neg;
        logic              ovf;
        logic              dz;
    } div_stage_t;

    div_stage_t        stage_reg [DIV_STAGES+1];
    div_stage_t        stage_next [DIV_STAGES+1];
    rsp_item_t         result_reg;
    rsp_item_t         result_next;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] hi;
    logic [DATA_W:0]   trial [DIV_STAGES];
    logic [DATA_W:0]   qr;
    logic              round_up;
    div_stage_t        last;

    // Prepare scaled numerator, detect zero divisor and early overflow,
    // then take one shift-subtract step per stage
    always_comb
    begin
        num = {mag(operand_a), {FRAC_BITS{1'b0}}};
        hi  = {{(DATA_W-FRAC_BITS){1'b0}}, num[NUM_W-1:DATA_W]};
        stage_next[0].dvsr = mag(operand_b);
        stage_next[0].dz   = (operand_b == '0);
        stage_next[0].ovf  = (hi >= mag(operand_b));
        stage_next[0].neg  = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        stage_next[0].rem  = hi;
        stage_next[0].low  = num[DATA_W-1:0];
        stage_next[0].quot = '0;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            trial[i]           = {stage_reg[i].rem, stage_reg[i].low[DATA_W-1]};
            stage_next[i+1]    = stage_reg[i];
            stage_next[i+1].low = {stage_reg[i].low[DATA_W-2:0], 1'b0};
            if (trial[i] >= {1'b0, stage_reg[i].dvsr})
            begin
                stage_next[i+1].rem  = DATA_W'(trial[i] - {1'b0, stage_reg[i].dvsr});
                stage_next[i+1].quot = {stage_reg[i].quot[DATA_W-2:0], 1'b1};
            end
            else
            begin
                stage_next[i+1].rem  = trial[i][DATA_W-1:0];
                stage_next[i+1].quot = {stage_reg[i].quot[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Round on remainder, restore sign, saturate
    always_comb
    begin
        last        = stage_reg[DIV_STAGES];
        round_up    = ({last.rem, 1'b0} >= {1'b0, last.dvsr});
        qr          = {1'b0, last.quot} + {{DATA_W{1'b0}}, round_up};
        result_next = '0;
        if (last.dz)
        begin
            result_next.divided_by_zero = 1'b1;
        end
        else if (last.ovf
                 || (last.neg && qr > {2'b01, {(DATA_W-1){1'b0}}})
                 || (!last.neg && qr > {2'b00, {(DATA_W-1){1'b1}}}))
        begin
            result_next.result_value = last.neg ? MIN_VAL : MAX_VAL;
            result_next.overflowed   = 1'b1;
        end
        else
        begin
            result_next.result_value = last.neg ? -qr[DATA_W-1:0] : qr[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/fixed_point_alu_top.sv =====
// Top level of the pipelined Q24.8 fixed-point ALU.
//
//  channel | direction | payload    | handshake
//  req     | in        | req_item_t | req_valid / req_stall
//  rsp     | out       | rsp_item_t | rsp_valid / rsp_stall
//
// One item enters per cycle unless the pipeline is held; each result leaves a
// pipeline whose depth is set by the 32 quotient-bit stages of the divider.
// All ops share that depth so results keep their order.
// The whole pipeline holds while a result waits under rsp_stall.
// Reset clears the valid bits only.
module fixed_point_alu_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  fpa_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fpa_pkg::rsp_item_t rsp
);
    import fpa_pkg::*;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        rsp_item_t           res;
    } early_t;

    logic                     adv;
    logic                     in_valid_reg;
    req_item_t                in_reg;
    early_t                   simple_next;
    early_t                   e1_reg;
    early_t                   e2_reg;
    logic                     e1_valid_reg;
    logic                     e2_valid_reg;
    early_t                   align_reg [ALIGN_DEPTH];
    logic [ALIGN_DEPTH-1:0]   align_valid_reg;
    early_t                   combined;
    rsp_item_t                mul_res;
    rsp_item_t                div_res;
    rsp_item_t                out_next;
    rsp_item_t                out_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W:0]   incd;
    logic signed [DATA_W:0]   decd;
    logic signed [NUM_W-1:0]  scaled;
    logic [DATA_W:0]          rnd;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;

    // Advance every stage unless a finished result is held
    assign adv       = !(out_valid_reg && rsp_stall);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            e1_valid_reg    <= 1'b0;
            e2_valid_reg    <= 1'b0;
            align_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg    <= req_valid;
            e1_valid_reg    <= in_valid_reg;
            e2_valid_reg    <= e1_valid_reg;
            align_valid_reg <= {align_valid_reg[ALIGN_DEPTH-2:0], e2_valid_reg};
            out_valid_reg   <= align_valid_reg[ALIGN_DEPTH-1];
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= req;
        end
    end

    fpa_mul u_mul (
        .clk       (clk),
        .en        (adv),
        .operand_a (in_reg.operand_a),
        .operand_b (in_reg.operand_b),
        .result    (mul_res)
    );

    fpa_div u_div (
        .clk       (clk),
        .en        (adv),
        .operand_a (in_reg.operand_a),
        .operand_b (in_reg.operand_b),
        .result    (div_res)
    );

    // Compute the simple operations combinationally
    always_comb
    begin
        a      = in_reg.operand_a;
        b      = in_reg.operand_b;
        sum    = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        diff   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        incd   = {a[DATA_W-1], a} + (DATA_W+1)'(1);
        decd   = {a[DATA_W-1], a} - (DATA_W+1)'(1);
        scaled = NUM_W'(a) <<< FRAC_BITS;
        rnd    = ({1'b0, mag(a)} + ((DATA_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        simple_next        = '0;
        simple_next.action = in_reg.action;
        case (in_reg.action)
            OP_ADD:
            begin
                if (sum[DATA_W] != sum[DATA_W-1])
                begin
                    simple_next.res.result_value = sum[DATA_W] ? MIN_VAL : MAX_VAL;
                    simple_next.res.overflowed   = 1'b1;
                end
                else
                begin
                    simple_next.res.result_value = sum[DATA_W-1:0];
                end
            end
            OP_SUB:
            begin
                if (diff[DATA_W] != diff[DATA_W-1])
                begin
                    simple_next.res.result_value = diff[DATA_W] ? MIN_VAL : MAX_VAL;
                    simple_next.res.overflowed   = 1'b1;
                end
                else
                begin
                    simple_next.res.result_value = diff[DATA_W-1:0];
                end
            end
            OP_INC:
            begin
                if (incd[DATA_W] != incd[DATA_W-1])
                begin
                    simple_next.res.result_value = MAX_VAL;
                    simple_next.res.overflowed   = 1'b1;
                end
                else
                begin
                    simple_next.res.result_value = incd[DATA_W-1:0];
                end
            end
            OP_DEC:
            begin
                if (decd[DATA_W] != decd[DATA_W-1])
                begin
                    simple_next.res.result_value = MIN_VAL;
                    simple_next.res.overflowed   = 1'b1;
                end
                else
                begin
                    simple_next.res.result_value = decd[DATA_W-1:0];
                end
            end
            OP_GT: simple_next.res.compare_true = (a > b);
            OP_LT: simple_next.res.compare_true = (a < b);
            OP_GE: simple_next.res.compare_true = (a >= b);
            OP_LE: simple_next.res.compare_true = (a <= b);
            OP_EQ: simple_next.res.compare_true = (a == b);
            OP_NE: simple_next.res.compare_true = (a != b);
            OP_MIN: simple_next.res.result_value = (a < b) ? a : b;
            OP_MAX: simple_next.res.result_value = (a > b) ? a : b;
            OP_FROM_INT:
            begin
                if (scaled[NUM_W-1:DATA_W-1] != {(FRAC_BITS+1){scaled[NUM_W-1]}})
                begin
                    simple_next.res.result_value = a[DATA_W-1] ? MIN_VAL : MAX_VAL;
                    simple_next.res.overflowed   = 1'b1;
                end
                else
                begin
                    simple_next.res.result_value = scaled[DATA_W-1:0];
                end
            end
            OP_TO_INT:
            begin
                simple_next.res.result_value = a[DATA_W-1] ? -rnd[DATA_W-1:0]
                                                           : rnd[DATA_W-1:0];
            end
            default: simple_next.res = '0;
        endcase
    end

    // Hold the simple results beside the multiplier stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= simple_next;
            e2_reg <= e1_reg;
        end
    end

    // Merge product, then delay to meet the divider output
    always_comb
    begin
        combined = e2_reg;
        if (e2_reg.action == OP_MUL)
        begin
            combined.res = mul_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            align_reg[0] <= combined;
            for (int i = 1; i < ALIGN_DEPTH; i++)
            begin
                align_reg[i] <= align_reg[i-1];
            end
        end
    end

    // Pick divider or aligned result for the output register
    always_comb
    begin
        out_next = align_reg[ALIGN_DEPTH-1].res;
        if (align_reg[ALIGN_DEPTH-1].action == OP_DIV)
        begin
            out_next = div_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
